// File: src/bfbcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfbcp_pkg: shared types and constants of the best-fit bar cutting packer
// Beat payloads, status and register index codes, and sequencer states.
// ----------------------------------------------------------------------------
package bfbcp_pkg;

   // field widths
   localparam int PIECE_W    = 16;
   localparam int USED_W     = 17;
   localparam int KERF_W     = 10;
   localparam int BAR_IDX_W  = 6;
   localparam int BAR_CNT_W  = 7;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [PIECE_W-1:0] CAPACITY_RESET = 16'd6000;
   localparam logic [KERF_W-1:0]  KERF_RESET     = 10'd0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BAR_CAPACITY = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAW_WIDTH    = 4'd1;

   // result status codes
   typedef enum logic [1:0] {
      STAT_PLACED   = 2'd0,
      STAT_NEW      = 2'd1,
      STAT_OVERSIZE = 2'd2,
      STAT_FULL     = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [PIECE_W-1:0] piece_length;
   } req_payload_type;

   typedef struct packed {
      status_type           status;
      logic [BAR_IDX_W-1:0] bar_index;
      logic [PIECE_W-1:0]   leftover;
      logic [BAR_CNT_W-1:0] bars_in_use;
   } rsp_payload_type;

endpackage

// File: src/bfbcp_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfbcp_stream_if: valid/ready channel
// Carries one payload beat per handshake, with source and sink views.
// ----------------------------------------------------------------------------
interface bfbcp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: src/best_fit_bar_cutting_packer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_bar_cutting_packer_core: best-fit packing of pieces into bars
// Keeps the used length of each open bar in a memory, scans it one bar a
// cycle for the tightest fit and places the piece there or in a new bar, or rejects it when the table is full.
// ----------------------------------------------------------------------------
//  channel   | dir | beat contents                               | handshake
//  ----------+-----+---------------------------------------------+-------------
//  req_chan  | in  | piece_length                                | valid/ready
//  rsp_chan  | out | status, bar_index, leftover, bars_in_use    | valid/ready
//  csr_*     | in  | csr_index, csr_wr_data                      | csr_wr_en
//
//  The time from accept to result grows with the open bars; an exact fit
//  ends the scan early. It is set by the single read port of the
//  bar memory, which the scan walks one bar per cycle.
//  Reset clears the bar count and loads the register reset values; the bar memory needs no clear.
//  A result waiting in the output register stalls only the final commit.
// ----------------------------------------------------------------------------
module best_fit_bar_cutting_packer_core #(
   parameter int MAX_BARS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   bfbcp_stream_if.sink                       req_chan,
   bfbcp_stream_if.source                     rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [bfbcp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bfbcp_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import bfbcp_pkg::*;

   localparam int IDX_W = $clog2(MAX_BARS);
   localparam int CNT_W = $clog2(MAX_BARS + 1);

   // control state
   state_type                 state_ff, state_in;
   logic [PIECE_W-1:0]        cap_ff, cap_in;
   logic [KERF_W-1:0]         kerf_ff, kerf_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          rd_idx_ff, rd_idx_in;
   logic                      cmp_vld_ff, cmp_vld_in;
   logic                      found_ff, found_in;
   logic                      rsp_vld_ff, rsp_vld_in;

   // payload state
   logic [PIECE_W-1:0]        piece_ff, piece_in;
   logic [IDX_W-1:0]          cmp_idx_ff, cmp_idx_in;
   logic [PIECE_W-1:0]        best_ff, best_in;
   logic [IDX_W-1:0]          pick_ff, pick_in;
   rsp_payload_type           rsp_data_ff, rsp_data_in;

   // bar memory
   logic [USED_W-1:0]         bar_used_mem [MAX_BARS];
   logic [USED_W-1:0]         rd_data_ff;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic [USED_W-1:0]         wr_data;

   // compare unit
   logic [USED_W:0]           total;
   logic                      fits;
   logic [PIECE_W-1:0]        diff;
   logic                      better;
   logic                      stop_hit;
   logic                      issue;
   logic                      commit;

   // shared compare: used + piece against capacity
   always_comb begin
      total    = {1'b0, rd_data_ff} + (USED_W+1)'(piece_ff);
      fits     = total <= (USED_W+1)'(cap_ff);
      diff     = cap_ff - total[PIECE_W-1:0];
      better   = cmp_vld_ff && fits && (diff < best_ff);
      stop_hit = better && (diff == '0);
      issue    = (rd_idx_ff < count_ff) && !stop_hit;
   end

   // sequencer, bookkeeping and result build
   always_comb begin
      state_in    = state_ff;
      cap_in      = cap_ff;
      kerf_in     = kerf_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      cmp_vld_in  = 1'b0;
      cmp_idx_in  = cmp_idx_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      pick_in     = pick_ff;
      piece_in    = piece_ff;
      rsp_data_in = rsp_data_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_chan.ready;
      wr_en       = 1'b0;
      wr_addr     = count_ff[IDX_W-1:0];
      wr_data     = USED_W'(piece_ff) + USED_W'(kerf_ff);
      commit      = 1'b0;

      // register writes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BAR_CAPACITY: cap_in  = csr_wr_data;
            CSR_SAW_WIDTH:    kerf_in = csr_wr_data[KERF_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               piece_in  = req_chan.payload.piece_length;
               best_in   = cap_ff;
               found_in  = 1'b0;
               pick_in   = '0;
               rd_idx_in = '0;
               state_in  = S_SCAN;
            end
         end

         S_SCAN: begin
            // take the compare result of the previous read
            if (better) begin
               best_in  = diff;
               pick_in  = cmp_idx_ff;
               found_in = 1'b1;
            end
            // next read, or wrap up
            if (issue) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff[IDX_W-1:0];
               rd_idx_in  = rd_idx_ff + 1'b1;
            end else begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               commit     = 1'b1;
               rsp_vld_in = 1'b1;
               state_in   = S_IDLE;
               if (found_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = pick_ff;
                  wr_data = USED_W'(cap_ff - best_ff) + USED_W'(kerf_ff);
                  rsp_data_in.status      = STAT_PLACED;
                  rsp_data_in.bar_index   = BAR_IDX_W'(pick_ff);
                  rsp_data_in.leftover    = best_ff;
                  rsp_data_in.bars_in_use = BAR_CNT_W'(count_ff);
               end else if (count_ff < CNT_W'(MAX_BARS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
                  rsp_data_in.bar_index   = BAR_IDX_W'(count_ff);
                  rsp_data_in.bars_in_use = BAR_CNT_W'(count_in);
                  if (piece_ff > cap_ff) begin
                     rsp_data_in.status   = STAT_OVERSIZE;
                     rsp_data_in.leftover = '0;
                  end else begin
                     rsp_data_in.status   = STAT_NEW;
                     rsp_data_in.leftover = cap_ff - piece_ff;
                  end
               end else begin
                  rsp_data_in.status      = STAT_FULL;
                  rsp_data_in.bar_index   = '0;
                  rsp_data_in.leftover    = '0;
                  rsp_data_in.bars_in_use = BAR_CNT_W'(count_ff);
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cap_ff     <= CAPACITY_RESET;
         kerf_ff    <= KERF_RESET;
         count_ff   <= '0;
         rd_idx_ff  <= '0;
         cmp_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cap_ff     <= cap_in;
         kerf_ff    <= kerf_in;
         count_ff   <= count_in;
         rd_idx_ff  <= rd_idx_in;
         cmp_vld_ff <= cmp_vld_in;
         found_ff   <= found_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      piece_ff    <= piece_in;
      cmp_idx_ff  <= cmp_idx_in;
      best_ff     <= best_in;
      pick_ff     <= pick_in;
      rsp_data_ff <= rsp_data_in;
   end

   // bar memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bar_used_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= bar_used_mem[rd_idx_ff[IDX_W-1:0]];
   end

   // ports
   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.payload = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // bar count never passes the table depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BARS))
      else $error("bar count above table depth");

   // the scan never reads past the open bars
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      rd_idx_ff <= count_ff)
      else $error("scan index beyond open bars");

   // the bar count only ever grows by one, and only on a commit
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + 1'b1) && $past(commit))
      else $error("bar count moved by other than one commit");

   // a rejection is only given with the table full
   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (commit && rsp_data_in.status == STAT_FULL) |-> count_ff == CNT_W'(MAX_BARS))
      else $error("rejection with free table entries");
`endif

endmodule

// File: test/tb_best_fit_bar_cutting_packer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_bar_cutting_packer_core: self-checking bench for the bar packer
// Sends a directed list of pieces and register writes, then random phases
// under several bar capacities and kerfs until the bar table is full. Every
// result beat is compared against a local best-fit model of the bar table, or against the values of a checked row.
// ----------------------------------------------------------------------------
module tb_best_fit_bar_cutting_packer_core;
   import bfbcp_pkg::*;

   localparam int BAR_SLOTS    = 64;
   localparam int IDLE_PCT     = 29;
   localparam int HOLD_AFTER   = 60;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 3000;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_PIECES = 69;
   localparam int STEADY_PHASE = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 4'd15;

   typedef enum logic {ROW_PIECE, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] value;
      logic                  fixed;
      rsp_payload_type       want;
   } row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   bfbcp_stream_if #(.payload_type(req_payload_type)) req_if ();
   bfbcp_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   best_fit_bar_cutting_packer_core #(.MAX_BARS(BAR_SLOTS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // local copy of the bar table and registers
   logic [USED_W-1:0]  used_len [BAR_SLOTS];
   int                 open_bars;
   logic [PIECE_W-1:0] capacity;
   logic [KERF_W-1:0]  kerf;

   rsp_payload_type placements_due [$];
   row_type         directed_rows [$];
   int              errors       = 0;
   int              results_seen = 0;
   bit              steady_flow  = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // best-fit placement of one piece, updates the local bar table
   function automatic rsp_payload_type place_piece(input logic [PIECE_W-1:0] piece);
      logic [USED_W:0]    total;
      logic [PIECE_W-1:0] best;
      logic [PIECE_W-1:0] gap;
      int                 pick;
      int                 i;
      bit                 found;
      rsp_payload_type    r;
      best  = capacity;
      pick  = 0;
      found = 1'b0;
      for (i = 0; i < open_bars; i++) begin
         total = {1'b0, used_len[i]} + (USED_W+1)'(piece);
         if (total <= (USED_W+1)'(capacity)) begin
            gap = capacity - total[PIECE_W-1:0];
            if (gap < best) begin
               best  = gap;
               pick  = i;
               found = 1'b1;
               if (gap == '0) break;
            end
         end
      end
      if (found) begin
         used_len[pick] = used_len[pick] + USED_W'(piece) + USED_W'(kerf);
         r.status       = STAT_PLACED;
         r.bar_index    = BAR_IDX_W'(pick);
         r.leftover     = best;
      end else if (open_bars < BAR_SLOTS) begin
         used_len[open_bars] = USED_W'(piece) + USED_W'(kerf);
         r.bar_index         = BAR_IDX_W'(open_bars);
         open_bars++;
         if (piece > capacity) begin
            r.status   = STAT_OVERSIZE;
            r.leftover = '0;
         end else begin
            r.status   = STAT_NEW;
            r.leftover = capacity - piece;
         end
      end else begin
         r.status    = STAT_FULL;
         r.bar_index = '0;
         r.leftover  = '0;
      end
      r.bars_in_use = BAR_CNT_W'(open_bars);
      return r;
   endfunction

   // random piece: exact fits, zero, max, oversize, coarse steps for ties
   function automatic logic [PIECE_W-1:0] pick_piece();
      int roll;
      int slot;
      int top;
      roll = $urandom_range(0, 99);
      top  = (capacity > 2) ? int'(capacity / 3) : 1;
      if (roll < 15 && open_bars > 0) begin
         slot = int'($urandom_range(0, open_bars - 1));
         if (used_len[slot] <= USED_W'(capacity))
            return PIECE_W'(USED_W'(capacity) - used_len[slot]);
         return PIECE_W'($urandom_range(0, top));
      end
      if (roll < 22) return '0;
      if (roll < 25) return '1;
      if (roll < 33 && capacity != '1) return PIECE_W'($urandom_range(capacity + 1, 65535));
      if (roll < 50) return PIECE_W'($urandom_range(1, 8) * (capacity / 8));
      return PIECE_W'($urandom_range(1, top));
   endfunction

   function automatic row_type piece_row(input logic [PIECE_W-1:0] piece);
      return '{ROW_PIECE, CSR_BAR_CAPACITY, piece, 1'b0, '0};
   endfunction

   function automatic row_type checked_row(input logic [PIECE_W-1:0] piece,
                                           input status_type st, input int bar,
                                           input int left, input int bars);
      return '{ROW_PIECE, CSR_BAR_CAPACITY, piece, 1'b1,
               '{st, BAR_IDX_W'(bar), PIECE_W'(left), BAR_CNT_W'(bars)}};
   endfunction

   function automatic row_type reg_row(input logic [CSR_IDX_W-1:0] idx,
                                       input logic [CSR_DATA_W-1:0] value);
      return '{ROW_REG, idx, value, 1'b0, '0};
   endfunction

   // wait until the packer has returned every result
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (placements_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // register write, only once the packer is idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      if (idx == CSR_BAR_CAPACITY) capacity = value;
      else if (idx == CSR_SAW_WIDTH) kerf = value[KERF_W-1:0];
   endtask

   // one piece beat; valid stays high unless the next step idles
   task automatic offer_piece(input logic [PIECE_W-1:0] piece, input logic fixed,
                              input rsp_payload_type want);
      rsp_payload_type due;
      while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= piece;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      due = place_piece(piece);
      placements_due.insert(placements_due.size(), fixed ? want : due);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   task automatic check_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (placements_due.size() == 0) begin
         errors++;
         $display("%0t: result beat with nothing expected, status %0d bar %0d",
                  $time, got.status, got.bar_index);
         return;
      end
      want = placements_due.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("bar_index", 32'(want.bar_index), 32'(got.bar_index));
      check_field("leftover", 32'(want.leftover), 32'(got.leftover));
      check_field("bars_in_use", 32'(want.bars_in_use), 32'(got.bars_in_use));
   endtask

   // stimulus: reset, directed rows, random phases, final drain
   initial begin
      row_type            row;
      int                 p;
      int                 n;
      logic [PIECE_W-1:0] phase_cap [PHASE_COUNT];
      logic [CSR_DATA_W-1:0] phase_kerf [PHASE_COUNT];
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_BAR_CAPACITY;
      csr_wr_data    = '0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      capacity       = CAPACITY_RESET;
      kerf           = KERF_RESET;
      open_bars      = 0;
      phase_cap  = '{16'hFFFF, 16'd6000, 16'($urandom_range(1, 65535)), 16'd1000,
                     16'($urandom_range(1, 65535)), 16'd1, 16'd0, 16'hFFFF};
      phase_kerf = '{16'd0, 16'd1023, 16'($urandom_range(0, 1023)), 16'd5,
                     16'($urandom_range(0, 65535)), 16'd0, 16'd1023, 16'd0};
      directed_rows = '{
         // empty table: a zero piece opens a bar with the whole length left
         checked_row(16'd0, STAT_NEW, 0, 6000, 1),
         // a bar left at full length is never picked, so another bar opens
         checked_row(16'd0, STAT_NEW, 1, 6000, 2),
         // exact fit ends the scan on bar 0
         checked_row(16'd6000, STAT_PLACED, 0, 0, 2),
         // oversize pieces still open bars
         checked_row(16'd6001, STAT_OVERSIZE, 2, 0, 3),
         checked_row(16'hFFFF, STAT_OVERSIZE, 3, 0, 4),
         piece_row(16'd1000),
         piece_row(16'd1000),
         reg_row(CSR_SAW_WIDTH, 16'd1023),
         piece_row(16'd3000),
         piece_row(16'd500),
         piece_row(16'd500),
         // capacity lowered below what some bars already hold
         reg_row(CSR_BAR_CAPACITY, 16'd2000),
         piece_row(16'd500),
         piece_row(16'd1500),
         // zero capacity: zero piece opens a bar with nothing left
         reg_row(CSR_BAR_CAPACITY, 16'd0),
         reg_row(CSR_SAW_WIDTH, 16'd0),
         piece_row(16'd0),
         piece_row(16'd1),
         // unused register index is ignored
         reg_row(CSR_SPARE, 16'hFFFF),
         piece_row(16'd0),
         reg_row(CSR_BAR_CAPACITY, 16'hFFFF),
         piece_row(16'hFFFF),
         piece_row(16'd1),
         reg_row(CSR_BAR_CAPACITY, 16'd1),
         piece_row(16'd1),
         piece_row(16'd2),
         piece_row(16'd0),
         reg_row(CSR_BAR_CAPACITY, CAPACITY_RESET),
         piece_row(16'd3000),
         piece_row(16'd3000)
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         if (row.kind == ROW_REG) write_reg(row.reg_idx, row.value);
         else offer_piece(row.value, row.fixed, row.want);
      end

      // random phases, the last ones fill the bar table
      for (p = 0; p < PHASE_COUNT; p++) begin
         write_reg(CSR_BAR_CAPACITY, phase_cap[p]);
         write_reg(CSR_SAW_WIDTH, phase_kerf[p]);
         steady_flow = (p == STEADY_PHASE);
         for (n = 0; n < PHASE_PIECES; n++) offer_piece(pick_piece(), 1'b0, '0);
      end
      steady_flow = 1'b0;

      drain_results();
      repeat (BAR_SLOTS + 8) @(posedge clock);
      if (errors == 0 && placements_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // result side: random stalls plus one long hold-off
   initial begin
      int hold_left;
      hold_left    = 0;
      rsp_if.ready = 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            check_result(rsp_if.payload);
            results_seen++;
            if (results_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // watchdog on cycles without any beat
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL");
      $finish;
   end

endmodule

// File: best_fit_bar_cutting_packer_core.f
src/bfbcp_pkg.sv
src/bfbcp_stream_if.sv
src/best_fit_bar_cutting_packer_core.sv
test/tb_best_fit_bar_cutting_packer_core.sv
